// ===== rtl/core/lac_pkg.sv =====
package lac_pkg;

  // Fixed-point scaling
  localparam int unsigned CHANNEL_SCALE_SHIFT = 10;
  localparam int unsigned RATIO_SCALE_SHIFT   = 9;
  localparam int unsigned LUX_SCALE_SHIFT     = 14;

  // Datasheet tables carry 9 ratio and 14 coefficient fraction bits
  localparam int unsigned TABLE_RATIO_SHIFT = 9;
  localparam int unsigned TABLE_LUX_SHIFT   = 14;
  localparam int unsigned GAIN_X1_SHIFT     = 4;

  localparam int unsigned CNT_W = 16;
  localparam int unsigned LUX_W = 20;
  localparam int unsigned SEG_N = 8;
  localparam int unsigned SEG_W = $clog2(SEG_N);

  // Register indexes on the write port
  typedef enum logic [0:0] {
    REG_INTEG_TIME = 1'b0,
    REG_GAIN_LOW   = 1'b1
  } lac_reg_e;

  // Integration time codes; the spare code behaves as the longest time
  typedef enum logic [1:0] {
    IT_13MS  = 2'd0,
    IT_101MS = 2'd1,
    IT_402MS = 2'd2
  } lac_itime_e;

  localparam int unsigned CFG_W = 2;

  // Channel factors, rounded to nearest
  localparam int unsigned ONE       = 1 << CHANNEL_SCALE_SHIFT;
  localparam int unsigned F_13MS    = (322 * ONE + 5) / 11;
  localparam int unsigned F_101MS   = (322 * ONE + 40) / 81;
  localparam int unsigned F_402MS   = ONE;
  localparam int unsigned FACTOR_W  = $clog2((F_13MS << GAIN_X1_SHIFT) + 1);
  localparam int unsigned MUL_W     = CNT_W + FACTOR_W;
  localparam int unsigned CH_W      = MUL_W - CHANNEL_SCALE_SHIFT;

  // Ratio dividend: ch1 shifted up by one more bit than the ratio scale
  localparam int unsigned DIV_W = CH_W + RATIO_SCALE_SHIFT + 1;

  localparam int unsigned SEG_BREAK [SEG_N-1] = '{
    32'h040, 32'h080, 32'h0C0, 32'h100, 32'h138, 32'h19A, 32'h29A
  };
  localparam int unsigned SEG_OFFSET [SEG_N] = '{
    32'h1F2, 32'h214, 32'h23F, 32'h270, 32'h16F, 32'h0D2, 32'h018, 32'h000
  };
  localparam int unsigned SEG_SLOPE [SEG_N] = '{
    32'h1BE, 32'h2D1, 32'h37B, 32'h3FE, 32'h1FC, 32'h0FB, 32'h012, 32'h000
  };

  // Largest unrounded quotient that still falls inside a breakpoint:
  // round(raw / 2) <= floor(brk * 2^R / 2^9)  <=>  raw <= 2 * that
  function automatic int unsigned seg_thr(int unsigned brk);
    return 2 * ((brk << RATIO_SCALE_SHIFT) >> TABLE_RATIO_SHIFT);
  endfunction

  // Coefficient rescaled to the lux fraction width, half rounded up
  function automatic int unsigned rescale_coef(int unsigned c);
    int unsigned up;
    int unsigned down;
    int unsigned v;
    up   = (LUX_SCALE_SHIFT >= TABLE_LUX_SHIFT) ? LUX_SCALE_SHIFT - TABLE_LUX_SHIFT : 0;
    down = (LUX_SCALE_SHIFT < TABLE_LUX_SHIFT) ? TABLE_LUX_SHIFT - LUX_SCALE_SHIFT : 0;
    v    = c << up;
    if (down > 0) begin
      v = (v + (1 << (down - 1))) >> down;
    end
    return v;
  endfunction

  // Quotient bits kept; anything larger saturates past the last breakpoint
  localparam int unsigned THR_MAX = seg_thr(SEG_BREAK[SEG_N-2]);
  localparam int unsigned QW      = $clog2(THR_MAX + 2);
  localparam int unsigned HI_W    = DIV_W - QW;
  localparam int unsigned CMP_W   = (HI_W > CH_W) ? HI_W : CH_W;

  localparam int unsigned COEF_MAX = rescale_coef(32'h3FE);
  localparam int unsigned COEF_W   = $clog2(COEF_MAX + 1);
  localparam int unsigned PROD_W   = CH_W + COEF_W;
  localparam int unsigned SUM_W    = PROD_W + 1;

  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [FACTOR_W-1:0] factor_t;
  typedef logic [MUL_W-1:0]    mul_t;
  typedef logic [CH_W-1:0]     ch_t;
  typedef logic [DIV_W-1:0]    div_t;
  typedef logic [CMP_W-1:0]    cmp_t;
  typedef logic [QW-1:0]       quo_t;
  typedef logic [COEF_W-1:0]   coef_t;
  typedef logic [PROD_W-1:0]   prod_t;
  typedef logic [SUM_W-1:0]    sum_t;
  typedef logic [LUX_W-1:0]    lux_t;
  typedef logic [SEG_W-1:0]    seg_t;

  // Configuration as seen by the front end
  typedef struct packed {
    logic [CFG_W-1:0] integ_time;
    logic             gain_low;
  } lac_cfg_t;

  // Word handed from cell to cell along the divider chain
  typedef struct packed {
    ch_t  ch0;
    ch_t  ch1;
    ch_t  rem;
    quo_t lo;
    quo_t quo;
    logic sat;
    logic zero;
  } lac_div_t;

endpackage

// ===== rtl/core/lac_front.sv =====
module lac_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lac_pkg::lac_cfg_t cfg_i,
  input  logic              vld_i,
  input  lac_pkg::cnt_t     broadband_i,
  input  lac_pkg::cnt_t     infrared_i,
  output logic              vld_o,
  output lac_pkg::lac_div_t dat_o
);

  logic              vld_a_q;
  lac_pkg::ch_t      ch0_q, ch0_d;
  lac_pkg::ch_t      ch1_q, ch1_d;
  lac_pkg::factor_t  base;
  lac_pkg::factor_t  factor;
  lac_pkg::mul_t     mul0, mul1;

  logic              vld_b_q;
  lac_pkg::lac_div_t dat_q, dat_d;
  lac_pkg::div_t     num;
  lac_pkg::cmp_t     hi;
  lac_pkg::cmp_t     den;

  // Channel factor from the integration time and gain
  always_comb begin
    unique case (cfg_i.integ_time)
      lac_pkg::IT_13MS:  base = lac_pkg::factor_t'(lac_pkg::F_13MS);
      lac_pkg::IT_101MS: base = lac_pkg::factor_t'(lac_pkg::F_101MS);
      default:           base = lac_pkg::factor_t'(lac_pkg::F_402MS);
    endcase
    factor = cfg_i.gain_low ? (base << lac_pkg::GAIN_X1_SHIFT) : base;
  end

  // Scale both channels
  always_comb begin
    mul0  = lac_pkg::mul_t'(broadband_i) * lac_pkg::mul_t'(factor);
    mul1  = lac_pkg::mul_t'(infrared_i) * lac_pkg::mul_t'(factor);
    ch0_d = mul0[lac_pkg::MUL_W-1:lac_pkg::CHANNEL_SCALE_SHIFT];
    ch1_d = mul1[lac_pkg::MUL_W-1:lac_pkg::CHANNEL_SCALE_SHIFT];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
    end else begin
      vld_a_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ch0_q <= ch0_d;
    ch1_q <= ch1_d;
  end

  // Divider set-up: quotient overflow check and the starting remainder
  always_comb begin
    num = {ch1_q, {(lac_pkg::RATIO_SCALE_SHIFT + 1){1'b0}}};
    hi  = lac_pkg::cmp_t'(num[lac_pkg::DIV_W-1:lac_pkg::QW]);
    den = lac_pkg::cmp_t'(ch0_q);
    dat_d.ch0  = ch0_q;
    dat_d.ch1  = ch1_q;
    dat_d.sat  = (hi >= den);
    dat_d.zero = (ch0_q == '0);
    dat_d.rem  = hi[lac_pkg::CH_W-1:0];
    dat_d.lo   = num[lac_pkg::QW-1:0];
    dat_d.quo  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_b_q <= 1'b0;
    end else begin
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dat_q <= dat_d;
  end

  assign vld_o = vld_b_q;
  assign dat_o = dat_q;

endmodule

// ===== rtl/core/lac_cell.sv =====
module lac_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  input  lac_pkg::lac_div_t dat_i,
  output logic              vld_o,
  output lac_pkg::lac_div_t dat_o
);

  logic                    vld_q;
  lac_pkg::lac_div_t       dat_q, dat_d;
  logic [lac_pkg::CH_W:0]  trial;
  logic [lac_pkg::CH_W:0]  diff;
  logic                    ge;

  // One restoring division step: bring down a dividend bit, try a subtract
  always_comb begin
    trial = {dat_i.rem, dat_i.lo[lac_pkg::QW-1]};
    ge    = (trial >= {1'b0, dat_i.ch0});
    diff  = trial - {1'b0, dat_i.ch0};
    dat_d      = dat_i;
    dat_d.rem  = ge ? diff[lac_pkg::CH_W-1:0] : trial[lac_pkg::CH_W-1:0];
    dat_d.lo   = dat_i.lo << 1;
    dat_d.quo  = {dat_i.quo[lac_pkg::QW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dat_q <= dat_d;
  end

  assign vld_o = vld_q;
  assign dat_o = dat_q;

endmodule

// ===== rtl/core/lac_back.sv =====
module lac_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  input  lac_pkg::lac_div_t dat_i,
  output logic              vld_o,
  output lac_pkg::lux_t     lux_o
);

  lac_pkg::quo_t   raw;
  lac_pkg::seg_t   seg;

  logic            vld_c_q;
  lac_pkg::ch_t    ch0_q, ch1_q;
  lac_pkg::coef_t  off_q, off_d;
  lac_pkg::coef_t  slope_q, slope_d;

  logic            vld_d_q;
  lac_pkg::prod_t  pos_q, pos_d;
  lac_pkg::prod_t  neg_q, neg_d;

  logic            vld_e_q;
  lac_pkg::lux_t   lux_q, lux_d;
  lac_pkg::sum_t   sum;
  lac_pkg::sum_t   lux_w;

  // Segment pick: first breakpoint the ratio does not exceed
  always_comb begin
    if (dat_i.zero) begin
      raw = '0;
    end else if (dat_i.sat) begin
      raw = '1;
    end else begin
      raw = dat_i.quo;
    end
    seg = lac_pkg::seg_t'(lac_pkg::SEG_N - 1);
    for (int i = lac_pkg::SEG_N - 2; i >= 0; i--) begin
      if (raw <= lac_pkg::quo_t'(lac_pkg::seg_thr(lac_pkg::SEG_BREAK[i]))) begin
        seg = lac_pkg::seg_t'(i);
      end
    end
    off_d   = lac_pkg::coef_t'(lac_pkg::rescale_coef(lac_pkg::SEG_OFFSET[seg]));
    slope_d = lac_pkg::coef_t'(lac_pkg::rescale_coef(lac_pkg::SEG_SLOPE[seg]));
  end

  // Products of each channel with its coefficient
  always_comb begin
    pos_d = lac_pkg::prod_t'(ch0_q) * lac_pkg::prod_t'(off_q);
    neg_d = lac_pkg::prod_t'(ch1_q) * lac_pkg::prod_t'(slope_q);
  end

  // Difference, round, clamp at zero and at full scale
  always_comb begin
    sum   = {1'b0, pos_q} - {1'b0, neg_q}
          + (lac_pkg::sum_t'(1) << (lac_pkg::LUX_SCALE_SHIFT - 1));
    lux_w = sum >> lac_pkg::LUX_SCALE_SHIFT;
    if (neg_q >= pos_q) begin
      lux_d = '0;
    end else if (|lux_w[lac_pkg::SUM_W-1:lac_pkg::LUX_W]) begin
      lux_d = '1;
    end else begin
      lux_d = lux_w[lac_pkg::LUX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_c_q <= 1'b0;
      vld_d_q <= 1'b0;
      vld_e_q <= 1'b0;
    end else begin
      vld_c_q <= vld_i;
      vld_d_q <= vld_c_q;
      vld_e_q <= vld_d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ch0_q   <= dat_i.ch0;
    ch1_q   <= dat_i.ch1;
    off_q   <= off_d;
    slope_q <= slope_d;
    pos_q   <= pos_d;
    neg_q   <= neg_d;
    lux_q   <= lux_d;
  end

  assign vld_o = vld_e_q;
  assign lux_o = lux_q;

endmodule

// ===== rtl/core/ambient_light_lux_calculator.sv =====
// Channel    Dir  Ports                                         Word moves when
// ---------  ---  --------------------------------------------  -------------------------
// sample     in   start_i, busy_o, broadband_count_i,           start_i high, busy_o low
//                 infrared_count_i
// result     out  lux_valid_o, lux_o                            lux_valid_o high
// config     in   cfg_we_i, cfg_idx_i, cfg_wdata_i              cfg_we_i high
//
// One sample word per cycle; busy_o stays low. Each result passes through the divider
// chain (QW quotient bits, 11 as built): two front stages, one cell per quotient bit,
// three back stages.
// Reset clears the valid bits and sets the registers to 101 ms and gain x1.
// The receiver cannot stall: each result is shown for exactly one cycle.
module ambient_light_lux_calculator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [15:0]               broadband_count_i,
  input  logic [15:0]               infrared_count_i,
  output logic                      lux_valid_o,
  output logic [19:0]               lux_o,
  input  logic                      cfg_we_i,
  input  logic [0:0]                cfg_idx_i,
  input  logic [lac_pkg::CFG_W-1:0] cfg_wdata_i
);

  logic [lac_pkg::CFG_W-1:0] integ_time_q;
  logic                      gain_low_q;
  lac_pkg::lac_cfg_t         cfg;

  logic                      vld [lac_pkg::QW+1];
  lac_pkg::lac_div_t         dat [lac_pkg::QW+1];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_time_q <= lac_pkg::IT_101MS;
      gain_low_q   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lac_pkg::REG_INTEG_TIME: integ_time_q <= cfg_wdata_i;
        lac_pkg::REG_GAIN_LOW:   gain_low_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign cfg.integ_time = integ_time_q;
  assign cfg.gain_low   = gain_low_q;

  // Fully pipelined: never refuses a sample
  assign busy_o = 1'b0;

  lac_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .vld_i       (start_i),
    .broadband_i (broadband_count_i),
    .infrared_i  (infrared_count_i),
    .vld_o       (vld[0]),
    .dat_o       (dat[0])
  );

  // Divider chain, one quotient bit per cell
  for (genvar g = 0; g < lac_pkg::QW; g++) begin : g_cell
    lac_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (vld[g]),
      .dat_i  (dat[g]),
      .vld_o  (vld[g+1]),
      .dat_o  (dat[g+1])
    );
  end

  lac_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (vld[lac_pkg::QW]),
    .dat_i  (dat[lac_pkg::QW]),
    .vld_o  (lux_valid_o),
    .lux_o  (lux_o)
  );

endmodule

// ===== bench/lux_checker.sv =====
module lux_checker
  import lac_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_o,
  input  cnt_t              broadband_count_i,
  input  cnt_t              infrared_count_i,
  input  logic              lux_valid_o,
  input  lux_t              lux_o,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  output int unsigned       errors_o,
  output int unsigned       pending_o
);

  // Fixed-point formats of the lux calculation
  localparam int unsigned FRAC_CH    = 10;
  localparam int unsigned FRAC_RATIO = 9;
  localparam int unsigned FRAC_LUX   = 14;
  localparam int unsigned KNEE_FRAC  = 9;
  localparam int unsigned GAIN_X1_SH = 4;
  localparam int unsigned N_SEG      = 8;
  localparam bit [63:0]   LUX_CEIL   = 64'd1048575;

  // Ratio breakpoints (9 fraction bits) and per-segment offset/slope (14 fraction bits)
  localparam bit [63:0] KNEE [N_SEG-1] = '{
    64'h040, 64'h080, 64'h0C0, 64'h100, 64'h138, 64'h19A, 64'h29A
  };
  localparam bit [63:0] SEG_B [N_SEG] = '{
    64'h1F2, 64'h214, 64'h23F, 64'h270, 64'h16F, 64'h0D2, 64'h018, 64'h000
  };
  localparam bit [63:0] SEG_M [N_SEG] = '{
    64'h1BE, 64'h2D1, 64'h37B, 64'h3FE, 64'h1FC, 64'h0FB, 64'h012, 64'h000
  };

  logic [CFG_W-1:0] cfg_itime;
  logic             cfg_gain_x1;
  lux_t             lux_expected_q [$];
  lux_t             lux_want;

  // Expected lux for one sample pair under the current settings
  function automatic lux_t predict_lux(cnt_t bb, cnt_t ir, logic [CFG_W-1:0] itime,
                                       logic gain_x1);
    bit [63:0] one;
    bit [63:0] factor;
    bit [63:0] ch0;
    bit [63:0] ch1;
    bit [63:0] quot;
    bit [63:0] ratio;
    bit [63:0] pos;
    bit [63:0] neg;
    bit [63:0] lux;
    int        seg;
    one = 64'd1 << FRAC_CH;
    case (itime)
      IT_13MS:  factor = (64'd322 * one + 64'd5) / 64'd11;
      IT_101MS: factor = (64'd322 * one + 64'd40) / 64'd81;
      default:  factor = one;  // 402 ms and the spare code
    endcase
    if (gain_x1) factor = factor << GAIN_X1_SH;
    ch0 = (64'(bb) * factor) >> FRAC_CH;
    ch1 = (64'(ir) * factor) >> FRAC_CH;
    // no broadband light: ratio taken as zero
    quot = '0;
    if (ch0 != 0) quot = (ch1 << (FRAC_RATIO + 1)) / ch0;
    ratio = (quot + 64'd1) >> 1;
    // first breakpoint at or above the ratio; past the last one lux is zero
    seg = N_SEG - 1;
    for (int k = N_SEG - 2; k >= 0; k--) begin
      if ((ratio << KNEE_FRAC) <= (KNEE[k] << FRAC_RATIO)) seg = k;
    end
    // table coefficients already carry FRAC_LUX fraction bits
    pos = ch0 * SEG_B[seg];
    neg = ch1 * SEG_M[seg];
    if (neg >= pos) return '0;
    lux = (pos - neg + (64'd1 << (FRAC_LUX - 1))) >> FRAC_LUX;
    if (lux > LUX_CEIL) lux = LUX_CEIL;
    return lux_t'(lux);
  endfunction

  // Compare results, queue predictions, track register writes
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_itime   = IT_101MS;
      cfg_gain_x1 = 1'b1;
      errors_o    = 0;
      pending_o   = 0;
    end else begin
      if (lux_valid_o !== 1'b0) begin
        if (lux_expected_q.size() == 0) begin
          $display("%0t: lux word with none expected: expected none, actual %0d (valid %b)",
                   $time, lux_o, lux_valid_o);
          errors_o++;
        end else begin
          lux_want = lux_expected_q.pop_front();
          if (lux_valid_o !== 1'b1 || lux_o !== lux_want) begin
            $display("%0t: lux mismatch: expected %0d, actual %0d (valid %b)",
                     $time, lux_want, lux_o, lux_valid_o);
            errors_o++;
          end
        end
      end
      if (start_i && !busy_o) begin
        lux_expected_q.push_back(predict_lux(broadband_count_i, infrared_count_i,
                                             cfg_itime, cfg_gain_x1));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_INTEG_TIME: cfg_itime   = cfg_wdata_i;
          REG_GAIN_LOW:   cfg_gain_x1 = cfg_wdata_i[0];
          default: ;
        endcase
      end
      pending_o = lux_expected_q.size();
    end
  end

endmodule

// ===== bench/tb_ambient_light_lux_calculator.sv =====
module tb_ambient_light_lux_calculator;
  import lac_pkg::*;

  // Sample-to-result delay of the block; drain waits use twice that
  localparam int unsigned LATENCY     = 16;
  localparam int unsigned RAND_PHASES = 10;
  localparam int unsigned PHASE_WORDS = 115;
  localparam logic [CFG_W-1:0] IT_SPARE = 2'd3;
  localparam logic [CFG_W-1:0] ITIME_SWEEP [4] = '{IT_13MS, IT_101MS, IT_402MS, IT_SPARE};
  // Ratio breakpoints, 9 fraction bits
  localparam int unsigned RATIO_KNEES [7] = '{
    'h040, 'h080, 'h0C0, 'h100, 'h138, 'h19A, 'h29A
  };

  typedef struct {
    cnt_t bb;
    cnt_t ir;
  } sample_t;

  logic             clk_i;
  logic             rst_ni            = 1'b0;
  logic             start_i           = 1'b0;
  logic             busy_o;
  cnt_t             broadband_count_i = '0;
  cnt_t             infrared_count_i  = '0;
  logic             lux_valid_o;
  lux_t             lux_o;
  logic             cfg_we_i          = 1'b0;
  logic [0:0]       cfg_idx_i         = '0;
  logic [CFG_W-1:0] cfg_wdata_i       = '0;
  int unsigned      errors;
  int unsigned      pending;
  sample_t          sample_q [$];

  ambient_light_lux_calculator i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .broadband_count_i (broadband_count_i),
    .infrared_count_i  (infrared_count_i),
    .lux_valid_o       (lux_valid_o),
    .lux_o             (lux_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  lux_checker i_lux_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .broadband_count_i (broadband_count_i),
    .infrared_count_i  (infrared_count_i),
    .lux_valid_o       (lux_valid_o),
    .lux_o             (lux_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .errors_o          (errors),
    .pending_o         (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #3000000;
    $display("== FAIL ==");
    $finish;
  end

  // Write both registers on consecutive cycles
  task automatic configure(logic [CFG_W-1:0] itime, logic gain_x1);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_INTEG_TIME;
    cfg_wdata_i <= itime;
    @(posedge clk_i);
    cfg_idx_i   <= REG_GAIN_LOW;
    cfg_wdata_i <= {1'($urandom_range(0, 1)), gain_x1};  // upper bit is don't-care
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Send queued words in bursts; start stays high across a burst
  task automatic play_samples();
    sample_t s;
    int      burst;
    int      gap;
    while (sample_q.size() > 0) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && sample_q.size() > 0) begin
        s = sample_q.pop_front();
        start_i           <= 1'b1;
        broadband_count_i <= s.bb;
        infrared_count_i  <= s.ir;
        @(posedge clk_i iff !busy_o);
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (sample_q.size() == 0 && gap == 0) gap = 1;
      if (gap > 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Block is idle once every word has come back and the pipe has drained
  task automatic drain();
    @(posedge clk_i);
    wait (pending == 0);
    repeat (2 * LATENCY) @(posedge clk_i);
  endtask

  initial begin
    sample_t          s;
    logic [CFG_W-1:0] itime;
    logic             gain_x1;
    bit [31:0]        scaled;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: field extremes, zero broadband, every breakpoint and just past it
    sample_q.push_back('{16'h0000, 16'h0000});
    sample_q.push_back('{16'hFFFF, 16'hFFFF});
    sample_q.push_back('{16'hFFFF, 16'h0000});
    sample_q.push_back('{16'h0000, 16'hFFFF});
    sample_q.push_back('{16'h0001, 16'h0000});
    sample_q.push_back('{16'h0001, 16'h0001});
    sample_q.push_back('{16'hFFFF, 16'hAAAA});
    sample_q.push_back('{16'h5555, 16'hFFFF});
    foreach (RATIO_KNEES[k]) begin
      sample_q.push_back('{16'd4096, cnt_t'(8 * RATIO_KNEES[k])});
      sample_q.push_back('{16'd4096, cnt_t'(8 * RATIO_KNEES[k] + 8)});
    end
    sample_q.push_back('{16'd3, 16'd4});
    sample_q.push_back('{16'd2, 16'd5});
    play_samples();
    drain();

    // Random phases: full sweep of settings first, then random ones
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p < 8) begin
        itime   = ITIME_SWEEP[p % 4];
        gain_x1 = (p >= 4);
      end else begin
        itime   = ITIME_SWEEP[2'($urandom_range(0, 3))];
        gain_x1 = 1'($urandom_range(0, 1));
      end
      configure(itime, gain_x1);
      repeat (PHASE_WORDS) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            s.bb = cnt_t'($urandom_range(0, 65535));
            s.ir = cnt_t'($urandom_range(0, 65535));
          end
          8: begin
            s.bb = cnt_t'($urandom_range(0, 15));
            s.ir = cnt_t'($urandom_range(0, 15));
          end
          9: begin
            s.bb = cnt_t'($urandom_range(0, 63));
            s.ir = cnt_t'($urandom_range(0, 65535));
          end
          default: begin
            // ratio spread over all segments and a little past the last
            s.bb   = cnt_t'($urandom_range(0, 65535) >> $urandom_range(0, 15));
            scaled = (32'(s.bb) * $urandom_range(0, 1400)) >> 10;
            s.ir   = (scaled > 32'hFFFF) ? 16'hFFFF : scaled[15:0];
          end
        endcase
        sample_q.push_back(s);
      end
      play_samples();
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== ambient_light_lux_calculator.f =====
rtl/core/lac_pkg.sv
rtl/core/lac_front.sv
rtl/core/lac_cell.sv
rtl/core/lac_back.sv
rtl/core/ambient_light_lux_calculator.sv
bench/lux_checker.sv
bench/tb_ambient_light_lux_calculator.sv
